### rtl/sbwm_pkg.sv
// Shared types and constants for the stream buffer watermark monitor.
`default_nettype none

package sbwm_pkg;

	// Buffer geometry
	localparam int BUFFER_BYTES = 12288;
	localparam int BLOCK_SHIFT  = 5;                    // 32-byte blocks
	localparam int LEVEL_W      = 14;
	localparam logic [LEVEL_W-1:0] BUF_FULL   = LEVEL_W'(BUFFER_BYTES);
	localparam logic [LEVEL_W-1:0] BUF_HALF   = LEVEL_W'(BUFFER_BYTES / 2);
	localparam logic [LEVEL_W-1:0] BUF_EIGHTH = LEVEL_W'(BUFFER_BYTES / 8);

	// Field widths
	localparam int LEN_W    = 14;
	localparam int BLK_W    = 8;
	localparam int TIMER_W  = 8;
	localparam int REG_W    = 7;
	localparam int WIN_W    = 7;
	localparam int TALLY_W  = 16;
	localparam int TOTAL_W  = 31;
	localparam int EST_W    = 16;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 96;

	// Averaged bandwidth: tally * block bytes * 8 bits, halved average stays below 2^BAND_W
	localparam int BAND_W    = TALLY_W + BLOCK_SHIFT + 3;
	// Divide by 800 = shift by 5, then multiply by ceil(2^24 / 25) and shift by 24
	localparam int DIV_SHIFT   = 5;
	localparam int DIV_IN_W    = BAND_W - DIV_SHIFT;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 24;
	localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(671089);

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Operation codes
	localparam logic OP_FILL = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_IDLE_RELOAD = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_RATE_WINDOW = 1'd1;

	typedef struct packed {
		logic             operation;
		logic [LEN_W-1:0] fill_length;
		logic [BLK_W-1:0] decoder_blocks;
	} sbwm_item_t;

	typedef struct packed {
		logic               fill_accepted;
		logic               draining;
		logic [BLK_W-1:0]   blocks_sent;
		logic [LEVEL_W-1:0] fill_level;
		logic [TIMER_W-1:0] idle_timer;
		logic [TALLY_W-1:0] frames_last_window;
		logic [EST_W-1:0]   bandwidth_estimate;
		logic [TOTAL_W-1:0] total_bytes;
		logic               timed_out;
	} sbwm_result_t;

endpackage

`default_nettype wire

### rtl/sbwm_in_reg.sv
// Input register stage: holds one request until the engine takes it.
`default_nettype none

module sbwm_in_reg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [sbwm_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire                          s_tuser,
	input  wire                          take,
	output logic                         valid_s1,
	output sbwm_pkg::sbwm_item_t         item_s1
);
	import sbwm_pkg::*;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation      <= s_tuser;
			item_s1.fill_length    <= s_tdata[LEN_W-1:0];
			item_s1.decoder_blocks <= s_tdata[LEN_W+BLK_W-1:LEN_W];
		end
	end

endmodule

`default_nettype wire

### rtl/sbwm_engine.sv
// Buffer state, configuration registers and the per-request update logic.
`default_nettype none

module sbwm_engine (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire [sbwm_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire [sbwm_pkg::REG_W-1:0]        cfg_data,
	input  wire                              fire,
	input  sbwm_pkg::sbwm_item_t             item,
	output sbwm_pkg::sbwm_result_t           res
);
	import sbwm_pkg::*;

	logic [REG_W-1:0]   reload_q;
	logic [REG_W-1:0]   rate_win_q;
	logic [LEVEL_W-1:0] level_q;
	logic               drain_q;
	logic [TIMER_W-1:0] timer_q;
	logic [WIN_W-1:0]   win_q;
	logic [TALLY_W-1:0] frame_tally_q;
	logic [TALLY_W-1:0] frames_snap_q;
	logic [TALLY_W-1:0] block_tally_q;
	logic [BAND_W-1:0]  band_q;
	logic [EST_W-1:0]   est_q;
	logic [TOTAL_W-1:0] total_q;

	logic [LEVEL_W-1:0] level_nx;
	logic               drain_nx;
	logic [TIMER_W-1:0] timer_nx;
	logic [WIN_W-1:0]   win_nx;
	logic [TALLY_W-1:0] frame_tally_nx;
	logic [TALLY_W-1:0] frames_snap_nx;
	logic [TALLY_W-1:0] block_tally_nx;
	logic [BAND_W-1:0]  band_nx;
	logic [EST_W-1:0]   est_nx;
	logic [TOTAL_W-1:0] total_nx;

	logic [LEVEL_W-1:0] free_bytes;
	logic               fits;
	logic [TOTAL_W:0]   total_sum;
	logic [WIN_W:0]     win_inc;
	logic               win_end;
	logic [BAND_W:0]    band_sum;
	logic [BAND_W-1:0]  band_new;
	logic [DIV_IN_W+RECIP_W-1:0] est_prod;
	logic               drain_mid;
	logic [LEVEL_W-BLOCK_SHIFT-1:0] avail;
	logic [BLK_W-1:0]   sent;
	logic [LEVEL_W-1:0] level_drained;
	logic [TALLY_W-1:0] tally_base;
	logic [TALLY_W:0]   tally_sum;
	logic               expire;

	// Fill path
	assign free_bytes = (level_q <= BUF_FULL) ? (BUF_FULL - level_q) : '0;
	assign fits       = item.fill_length <= free_bytes;
	assign total_sum  = {1'b0, total_q} + (TOTAL_W+1)'(item.fill_length);

	// Window end and averaged bandwidth
	assign win_inc  = {1'b0, win_q} + 1'b1;
	assign win_end  = win_inc >= {1'b0, rate_win_q};
	assign band_sum = {1'b0, band_q} + {1'b0, block_tally_q, {(BLOCK_SHIFT+3){1'b0}}};
	assign band_new = band_sum[BAND_W:1];
	assign est_prod = (DIV_IN_W+RECIP_W)'(band_new[BAND_W-1:DIV_SHIFT])
	                  * (DIV_IN_W+RECIP_W)'(RECIP_25);

	// Hysteresis is judged on the level before this tick's drain
	always_comb begin
		priority if (level_q > BUF_HALF) begin
			drain_mid = 1'b1;
		end else if (level_q < BUF_EIGHTH) begin
			drain_mid = 1'b0;
		end else begin
			drain_mid = drain_q;
		end
	end

	assign avail = level_q[LEVEL_W-1:BLOCK_SHIFT];
	always_comb begin
		if (!drain_mid) begin
			sent = '0;
		end else if ((LEVEL_W-BLOCK_SHIFT)'(item.decoder_blocks) < avail) begin
			sent = item.decoder_blocks;
		end else begin
			sent = BLK_W'(avail);
		end
	end
	assign level_drained = level_q - {LEVEL_W-BLK_W-BLOCK_SHIFT > 0 ? 1'b0 : 1'b0,
	                                  sent, {BLOCK_SHIFT{1'b0}}};

	assign tally_base = win_end ? '0 : block_tally_q;
	assign tally_sum  = {1'b0, tally_base} + (TALLY_W+1)'(sent);
	assign expire     = (timer_q == TIMER_W'(1)) && (sent == '0);

	always_comb begin
		level_nx       = level_q;
		drain_nx       = drain_q;
		timer_nx       = timer_q;
		win_nx         = win_q;
		frame_tally_nx = frame_tally_q;
		frames_snap_nx = frames_snap_q;
		block_tally_nx = block_tally_q;
		band_nx        = band_q;
		est_nx         = est_q;
		total_nx       = total_q;
		res            = '0;

		unique case (item.operation)
			OP_FILL: begin
				if (frame_tally_q != TALLY_MAX) begin
					frame_tally_nx = frame_tally_q + 1'b1;
				end
				if (fits) begin
					level_nx = level_q + item.fill_length;
					total_nx = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
					timer_nx = TIMER_W'(reload_q);
				end
				res.fill_accepted = fits;
			end
			OP_TICK: begin
				if (win_end) begin
					win_nx         = '0;
					frames_snap_nx = frame_tally_q;
					frame_tally_nx = '0;
					band_nx        = band_new;
					est_nx         = EST_W'(est_prod >> RECIP_SHIFT);
				end else begin
					win_nx = win_inc[WIN_W-1:0];
				end
				drain_nx       = drain_mid;
				level_nx       = level_drained;
				block_tally_nx = tally_sum[TALLY_W] ? TALLY_MAX : tally_sum[TALLY_W-1:0];
				if (timer_q != '0) begin
					if (sent == '0) begin
						timer_nx = timer_q - 1'b1;
					end else if (timer_q <= TIMER_W'(reload_q)) begin
						timer_nx = timer_q + 1'b1;
					end
				end
				if (expire) begin
					drain_nx = 1'b0;
					level_nx = '0;
					total_nx = '0;
				end
				res.blocks_sent = sent;
				res.timed_out   = expire;
			end
			default: begin
			end
		endcase

		res.draining           = drain_nx;
		res.fill_level         = level_nx;
		res.idle_timer         = timer_nx;
		res.frames_last_window = frames_snap_nx;
		res.bandwidth_estimate = est_nx;
		res.total_bytes        = total_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q   <= REG_W'(100);
			rate_win_q <= REG_W'(100);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IDLE_RELOAD: reload_q   <= cfg_data;
				REG_RATE_WINDOW: rate_win_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= '0;
			drain_q       <= 1'b0;
			timer_q       <= '0;
			win_q         <= '0;
			frame_tally_q <= '0;
			frames_snap_q <= '0;
			block_tally_q <= '0;
			band_q        <= '0;
			est_q         <= '0;
			total_q       <= '0;
		end else if (fire) begin
			level_q       <= level_nx;
			drain_q       <= drain_nx;
			timer_q       <= timer_nx;
			win_q         <= win_nx;
			frame_tally_q <= frame_tally_nx;
			frames_snap_q <= frames_snap_nx;
			block_tally_q <= block_tally_nx;
			band_q        <= band_nx;
			est_q         <= est_nx;
			total_q       <= total_nx;
		end
	end

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= BUF_FULL)
		else $error("buffer level above capacity");

	a_timeout_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.timed_out |=> level_q == '0 && !drain_q && total_q == '0)
		else $error("timeout did not empty the buffer");

	a_drain_within_level: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.operation == OP_TICK |->
			{1'b0, res.blocks_sent, {BLOCK_SHIFT{1'b0}}} <= {1'b0, level_q})
		else $error("drained more bytes than held");

	a_fill_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.operation == OP_FILL && res.fill_accepted |=>
			timer_q == TIMER_W'($past(reload_q)))
		else $error("accepted fill did not reload the idle timer");

	a_high_level_drains: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.operation == OP_TICK && !res.timed_out
			&& res.fill_level > BUF_HALF |=> drain_q)
		else $error("draining off above the high watermark");
`endif

endmodule

`default_nettype wire

### rtl/sbwm_out_reg.sv
// Result register on the master side.
`default_nettype none

module sbwm_out_reg (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            fire,
	input  sbwm_pkg::sbwm_result_t         res,
	output logic                           take,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [sbwm_pkg::OUT_DATA_W-1:0] m_tdata
);
	import sbwm_pkg::*;

	sbwm_result_t res_q;

	assign take = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_tdata = {res_q.timed_out,
	                  res_q.total_bytes,
	                  res_q.bandwidth_estimate,
	                  res_q.frames_last_window,
	                  res_q.idle_timer,
	                  res_q.fill_level,
	                  res_q.blocks_sent,
	                  res_q.draining,
	                  res_q.fill_accepted};

endmodule

`default_nettype wire

### rtl/stream_buffer_watermark_monitor_top.sv
// Top level of the stream buffer watermark monitor.
//
// Channel  Dir  Contents
// s_*      in   request: tuser = operation (0 fill, 1 tick); tdata = fill_length, decoder_blocks
// m_*      out  one result per request, fields listed at m_tdata
// cfg_*    in   register write: 0 idle_reload_ticks, 1 rate_window_ticks
//
// One request a cycle unless m_tready stalls; each result is registered when the engine fires.
// The whole update is one pass through the engine between input and result registers.
// The bandwidth divide by 800 is a shift and one reciprocal multiply in that pass.
// A stall on m_tready holds the result; s_tready drops only when both stages are full.
// Reset clears the valid flags and all buffer state; both registers come up at 100.
`default_nettype none

module stream_buffer_watermark_monitor_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [13:0] fill_length, [21:14] decoder_blocks, [23:22] zero
	input  wire  [23:0] s_tdata,
	// [0] operation
	input  wire         s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [0] fill_accepted, [1] draining, [9:2] blocks_sent, [23:10] fill_level,
	// [31:24] idle_timer, [47:32] frames_last_window, [63:48] bandwidth_estimate,
	// [94:64] total_bytes, [95] timed_out
	output logic [95:0] m_tdata,
	input  wire         cfg_wr_en,
	input  wire  [0:0]  cfg_index,
	input  wire  [6:0]  cfg_data
);
	import sbwm_pkg::*;

	logic         take;
	logic         valid_s1;
	logic         fire;
	sbwm_item_t   item_s1;
	sbwm_result_t res;

	assign fire = valid_s1 && take;

	sbwm_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sbwm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item      (item_s1),
		.res       (res)
	);

	sbwm_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.res      (res),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stream buffer watermark monitor top level.
module tb_top;
	import sbwm_pkg::*;

	localparam int BLOCK_BYTES  = 1 << BLOCK_SHIFT;
	localparam int BAND_DIV     = 800;
	localparam int REPORT_LIMIT = 10;
	localparam int SETTLE_LIMIT = 2000;
	localparam int FIELD_COUNT  = 9;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	// [13:0] fill_length, [21:14] decoder_blocks, [23:22] zero
	logic [IN_DATA_W-1:0] s_tdata = '0;
	// [0] operation
	logic s_tuser = 1'b0;
	logic m_tready = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;
	wire s_tready;
	wire m_tvalid;
	// fill_accepted, draining, blocks_sent, fill_level, idle_timer,
	// frames_last_window, bandwidth_estimate, total_bytes, timed_out (lowest bit up)
	wire [OUT_DATA_W-1:0] m_tdata;

	stream_buffer_watermark_monitor_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result field layout on m_tdata
	int    field_lo   [FIELD_COUNT] = '{0, 1, 2, 10, 24, 32, 48, 64, 95};
	int    field_w    [FIELD_COUNT] = '{1, 1, 8, 14, 8, 16, 16, 31, 1};
	string field_name [FIELD_COUNT] = '{"fill_accepted", "draining", "blocks_sent",
		"fill_level", "idle_timer", "frames_last_window", "bandwidth_estimate",
		"total_bytes", "timed_out"};

	logic [OUT_DATA_W-1:0] expected_results [$];
	int mismatch_count = 0;
	int src_gap_max = 6;
	int sink_gap_max = 6;
	int sink_hold = 0;

	// buffer state as the block should hold it
	logic [REG_W-1:0]   reload_ticks = 7'd100;
	logic [REG_W-1:0]   window_len   = 7'd100;
	logic [LEVEL_W-1:0] level        = '0;
	logic               drain_on     = 1'b0;
	logic [TIMER_W-1:0] idle_count   = '0;
	logic [WIN_W-1:0]   win_count    = '0;
	logic [TALLY_W-1:0] frame_count  = '0;
	logic [TALLY_W-1:0] frame_snap   = '0;
	logic [TALLY_W-1:0] block_count  = '0;
	logic [31:0]        band_avg     = '0;
	logic [TOTAL_W-1:0] byte_total   = '0;

	function automatic logic [OUT_DATA_W-1:0] predict_result(input sbwm_item_t it);
		sbwm_result_t r;
		int unsigned space;
		int unsigned sent;
		longint unsigned sum;
		r = '0;
		sent = 0;
		space = BUFFER_BYTES - level;
		if (it.operation == OP_FILL) begin
			if (frame_count != TALLY_MAX)
				frame_count = frame_count + 1'b1;
			if (it.fill_length <= space) begin
				r.fill_accepted = 1'b1;
				level = level + it.fill_length;
				if (longint'(byte_total) + longint'(it.fill_length) > longint'(TOTAL_MAX))
					byte_total = TOTAL_MAX;
				else
					byte_total = byte_total + it.fill_length;
				idle_count = {1'b0, reload_ticks};
			end
		end else begin
			// window close comes before this tick's drain
			if (int'(win_count) + 1 >= int'(window_len)) begin
				sum = longint'(band_avg) + longint'(block_count) * BLOCK_BYTES * 8;
				band_avg = 32'(sum / 2);
				win_count = '0;
				frame_snap = frame_count;
				frame_count = '0;
				block_count = '0;
			end else begin
				win_count = win_count + 1'b1;
			end
			space = BUFFER_BYTES - level;
			if (space < BUFFER_BYTES / 2)
				drain_on = 1'b1;
			else if (level < BUFFER_BYTES / 8)
				drain_on = 1'b0;
			if (drain_on) begin
				sent = level / BLOCK_BYTES;
				if (it.decoder_blocks < sent)
					sent = it.decoder_blocks;
				level = level - LEVEL_W'(sent * BLOCK_BYTES);
				if (block_count + sent > TALLY_MAX)
					block_count = TALLY_MAX;
				else
					block_count = TALLY_W'(block_count + sent);
			end
			if (idle_count != 0) begin
				if (sent == 0)
					idle_count = idle_count - 1'b1;
				else if (idle_count <= reload_ticks)
					idle_count = idle_count + 1'b1;
				if (idle_count == 0) begin
					drain_on = 1'b0;
					level = '0;
					byte_total = '0;
					r.timed_out = 1'b1;
				end
			end
			r.blocks_sent = BLK_W'(sent);
		end
		r.draining = drain_on;
		r.fill_level = level;
		r.idle_timer = idle_count;
		r.frames_last_window = frame_snap;
		r.bandwidth_estimate = EST_W'(band_avg / BAND_DIV);
		r.total_bytes = byte_total;
		return {r.timed_out, r.total_bytes, r.bandwidth_estimate, r.frames_last_window,
			r.idle_timer, r.fill_level, r.blocks_sent, r.draining, r.fill_accepted};
	endfunction

	// entered just after a rising edge; leaves s_tvalid high for the next request
	task automatic send_request(input logic op, input logic [LEN_W-1:0] len,
			input logic [BLK_W-1:0] blocks);
		sbwm_item_t it;
		int gap;
		it.operation = op;
		it.fill_length = len;
		it.decoder_blocks = blocks;
		gap = $urandom_range(0, src_gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, blocks, len};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		expected_results.push_back(predict_result(it));
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_IDLE_RELOAD)
			reload_ticks = value;
		else
			window_len = value;
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 3))
			0: pick_length = LEN_W'($urandom_range(0, BUFFER_BYTES));
			1: pick_length = LEN_W'($urandom_range(0, 512));
			2: pick_length = LEN_W'(BUFFER_BYTES - level);
			default: pick_length = LEN_W'(BUFFER_BYTES);
		endcase
	endfunction

	function automatic logic [BLK_W-1:0] pick_blocks();
		case ($urandom_range(0, 3))
			0: pick_blocks = '0;
			1: pick_blocks = '1;
			2: pick_blocks = BLK_W'($urandom_range(0, 255));
			default: pick_blocks = BLK_W'($urandom_range(0, 16));
		endcase
	endfunction

	// result checker: handshake seen mid-cycle completes at the next rising edge
	always @(negedge clk) begin : result_check
		logic [OUT_DATA_W-1:0] want;
		logic [OUT_DATA_W-1:0] mask;
		int f;
		if (arst_n && m_tvalid && m_tready) begin
			sink_hold = $urandom_range(0, sink_gap_max);
			if (expected_results.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("unexpected result %h", m_tdata);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				for (f = 0; f < FIELD_COUNT; f++) begin
					mask = (96'd1 << field_w[f]) - 96'd1;
					if (((m_tdata >> field_lo[f]) & mask) !== ((want >> field_lo[f]) & mask)) begin
						if (mismatch_count < REPORT_LIMIT)
							$display("%s mismatch: expected %0h, got %0h", field_name[f],
								(want >> field_lo[f]) & mask, (m_tdata >> field_lo[f]) & mask);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (sink_hold != 0) begin
			m_tready <= 1'b0;
			sink_hold = sink_hold - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic test_fill_and_drain();
		send_request(OP_TICK, '0, '0);
		send_request(OP_FILL, '0, 8'hFF);             // empty fill still reloads the timer
		send_request(OP_FILL, LEN_W'(BUFFER_BYTES), '0);
		send_request(OP_FILL, 14'd1, '0);             // no room: rejected, still a frame
		send_request(OP_TICK, LEN_W'(BUFFER_BYTES), '0);
		send_request(OP_TICK, '0, 8'hFF);
		send_request(OP_TICK, '0, 8'hFF);             // partial offer empties it
		send_request(OP_TICK, 14'h0FFF, 8'hFF);       // below an eighth: drain off
		send_request(OP_FILL, 14'd6145, '0);          // just past half
		send_request(OP_TICK, '0, 8'd1);
		send_request(OP_TICK, '0, 8'hFF);
		send_request(OP_TICK, '0, '0);
		settle();
	endtask

	task automatic test_idle_timer();
		write_register(REG_IDLE_RELOAD, 7'd2);
		send_request(OP_FILL, 14'd100, '0);
		send_request(OP_TICK, '0, '0);
		send_request(OP_TICK, '0, '0);                // expiry empties the buffer
		send_request(OP_TICK, '0, '0);
		settle();
		write_register(REG_IDLE_RELOAD, 7'd1);
		send_request(OP_FILL, 14'd7000, '0);
		send_request(OP_TICK, '0, 8'd10);
		send_request(OP_TICK, '0, 8'd10);             // timer held at reload + 1
		settle();
		write_register(REG_IDLE_RELOAD, 7'd0);
		send_request(OP_FILL, 14'd64, '0);            // zero reload leaves the timer idle
		send_request(OP_TICK, '0, '0);
		settle();
	endtask

	task automatic test_rate_window();
		write_register(REG_RATE_WINDOW, 7'd0);
		write_register(REG_IDLE_RELOAD, 7'd127);
		send_request(OP_FILL, LEN_W'(BUFFER_BYTES - level), '0);
		send_request(OP_TICK, '0, 8'hFF);
		send_request(OP_TICK, '0, 8'hFF);
		settle();
		write_register(REG_RATE_WINDOW, 7'd3);
		send_request(OP_FILL, LEN_W'(BUFFER_BYTES - level), '0);
		repeat (4) send_request(OP_TICK, '0, 8'd200);
		settle();
		write_register(REG_RATE_WINDOW, 7'd1);
	endtask

	task automatic test_random_traffic();
		int chunk;
		logic [REG_W-1:0] value;
		for (chunk = 0; chunk < 8; chunk++) begin
			case ($urandom_range(0, 4))
				0: value = 7'd0;
				1: value = 7'd1;
				2: value = 7'd127;
				default: value = REG_W'($urandom_range(2, 20));
			endcase
			write_register(REG_IDLE_RELOAD, value);
			case ($urandom_range(0, 3))
				0: value = 7'd0;
				1: value = 7'd127;
				default: value = REG_W'($urandom_range(1, 12));
			endcase
			write_register(REG_RATE_WINDOW, value);
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			repeat (50) begin
				if ($urandom_range(0, 9) < 4)
					send_request(OP_FILL, pick_length(), BLK_W'($urandom_range(0, 255)));
				else
					send_request(OP_TICK, LEN_W'($urandom_range(0, BUFFER_BYTES)), pick_blocks());
			end
			settle();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_and_drain();
		test_idle_timer();
		test_rate_window();
		test_random_traffic();
		settle();
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("PASS stream_buffer_watermark_monitor_top");
		else
			$display("FAIL stream_buffer_watermark_monitor_top");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("FAIL stream_buffer_watermark_monitor_top");
		$finish;
	end

endmodule

### filelist.f
rtl/sbwm_pkg.sv
rtl/sbwm_in_reg.sv
rtl/sbwm_engine.sv
rtl/sbwm_out_reg.sv
rtl/stream_buffer_watermark_monitor_top.sv
sim/tb_top.sv
